[design/keyframe_position_interpolator_macros.svh]
// assertion macros shared by the keyframe interpolator modules
// expects clk and rst_n in the scope of each use
`ifndef KEYFRAME_POSITION_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_POSITION_INTERPOLATOR_MACROS_SVH

// property checked on every edge outside reset
`define KPI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define KPI_ASSERT_NEXT(lbl, pre, post, msg) \
  `KPI_ASSERT_RST(lbl, (pre) |=> (post), msg)

`endif

[design/kpi_pkg.sv]
// types and constants of the keyframe position interpolator
// no dependencies
`timescale 1ns / 1ps

package kpi_pkg;

  localparam int NW = 11;
  localparam int CW = 20;
  localparam int WW = 16;

  typedef logic [NW-1:0] cnt_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_WR_POS = 2'd0,
    KIND_WR_KEY = 2'd1,
    KIND_WR_CUR = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RA_F    = 2'd0,
    RA_IDX  = 2'd1,
    RA_PREV = 2'd2,
    RA_NEXT = 2'd3
  } rsel_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CUR,
    ST_KEY,
    ST_PREV_RD,
    ST_PREV_CHK,
    ST_NEXT_RD,
    ST_NEXT_CHK,
    ST_RESOLVE,
    ST_POS,
    ST_DIV,
    ST_LD_P,
    ST_LD_Q,
    ST_MUL_X,
    ST_MUL_Y,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  clr;
    logic  load;
    logic  wr;
    rsel_t rsel;
    logic  idx_f_m1;
    logic  idx_f_p1;
    logic  idx_dec;
    logic  idx_inc;
    logic  set_prev;
    logic  set_next;
    logic  div_init;
    logic  div_step;
    logic  lat_a;
    logic  lat_b;
    logic  mul_x;
    logic  mul_y;
    logic  fin;
    logic  res_zero;
    logic  res_cur;
    logic  res_pos;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_t kind;
    logic  pt_ok;
    logic  f_ok;
    logic  key;
    logic  f_zero;
    logic  idx_zero;
    logic  f1_ge_n;
    logic  idx1_ge_n;
    logic  has_prev;
    logic  has_next;
    logic  div_last;
    logic  out_busy;
  } sts_t;

endpackage

[design/keyframe_position_interpolator.sv]
// keyframe position interpolator: stores per point frame positions, keyframe
// flags and current positions, and answers position queries
// depends on kpi_pkg, kpi_ctrl, kpi_dp and kpi_ram
//
// usage:
//   in_* is a valid/ready request channel: kind 0 writes a frame position,
//   1 a keyframe flag, 2 the current position, 3 is a query
//   out_* is a valid/ready result channel, one result per query only
//   cfg_we/cfg_wdata write frame_count; the user must do so only while the
//   block is idle, as the block itself does not enforce it
// timing:
//   a write ends in the decode state; keyed and out of range queries need
//   no scan; an unkeyed query scans the flag memory, a read and a check per
//   frame, first down to the previous keyframe, then up to the next one;
//   two keyframes add a restoring divide, then reads and blending
//   one request is processed at a time
// reset:
//   after reset the memories are cleared, one entry per cycle over all
//   MAX_POINTS * MAX_FRAMES entries, and no request is taken until then
// stall:
//   a result waits in the output register while out_ready is low; the next
//   request is still taken, and a following query holds when it completes
`timescale 1ns / 1ps

module keyframe_position_interpolator #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_FRAMES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_point,
  input  logic [9:0]  in_frame_index,
  input  logic [19:0] in_pos_x,
  input  logic [19:0] in_pos_y,
  input  logic        in_key_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_x,
  output logic [19:0] out_y,
  output logic        out_found,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  import kpi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kpi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  kpi_dp #(.MAX_POINTS(MAX_POINTS), .MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_kind(in_kind), .in_point(in_point), .in_frame_index(in_frame_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_key_flag(in_key_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_found(out_found)
  );

endmodule

[design/kpi_ram.sv]
// generic single write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module kpi_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/kpi_ctrl.sv]
// controller state machine of the keyframe interpolator
// depends on kpi_pkg and the macros header
`timescale 1ns / 1ps
`include "keyframe_position_interpolator_macros.svh"

module kpi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kpi_pkg::sts_t sts,
  output kpi_pkg::cmd_t cmd
);

  import kpi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.rsel = RA_F;
        if (sts.kind != KIND_QUERY) begin
          cmd.wr    = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!sts.pt_ok) begin
          cmd.res_zero = 1'b1;
          state_nxt    = ST_DONE;
        end else if (!sts.f_ok) begin
          state_nxt = ST_CUR;
        end else begin
          state_nxt = ST_KEY;
        end
      end
      ST_CUR: begin
        cmd.res_cur = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_KEY: begin
        if (sts.key) begin
          cmd.res_pos = 1'b1;
          state_nxt   = ST_DONE;
        end else if (!sts.f_zero) begin
          cmd.idx_f_m1 = 1'b1;
          state_nxt    = ST_PREV_RD;
        end else if (sts.f1_ge_n) begin
          state_nxt = ST_RESOLVE;
        end else begin
          cmd.idx_f_p1 = 1'b1;
          state_nxt    = ST_NEXT_RD;
        end
      end
      ST_PREV_RD: begin
        cmd.rsel  = RA_IDX;
        state_nxt = ST_PREV_CHK;
      end
      ST_PREV_CHK: begin
        if (!sts.key && !sts.idx_zero) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = ST_PREV_RD;
        end else begin
          cmd.set_prev = sts.key;
          if (sts.f1_ge_n) begin
            state_nxt = ST_RESOLVE;
          end else begin
            cmd.idx_f_p1 = 1'b1;
            state_nxt    = ST_NEXT_RD;
          end
        end
      end
      ST_NEXT_RD: begin
        cmd.rsel  = RA_IDX;
        state_nxt = ST_NEXT_CHK;
      end
      ST_NEXT_CHK: begin
        if (sts.key) begin
          cmd.set_next = 1'b1;
          state_nxt    = ST_RESOLVE;
        end else if (sts.idx1_ge_n) begin
          state_nxt = ST_RESOLVE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_NEXT_RD;
        end
      end
      ST_RESOLVE: begin
        if (sts.has_prev && sts.has_next) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else if (sts.has_prev) begin
          cmd.rsel  = RA_PREV;
          state_nxt = ST_POS;
        end else if (sts.has_next) begin
          cmd.rsel  = RA_NEXT;
          state_nxt = ST_POS;
        end else begin
          cmd.res_cur = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_POS: begin
        cmd.res_pos = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.rsel     = RA_PREV;
        if (sts.div_last) begin
          state_nxt = ST_LD_P;
        end
      end
      ST_LD_P: begin
        cmd.lat_a = 1'b1;
        cmd.rsel  = RA_NEXT;
        state_nxt = ST_LD_Q;
      end
      ST_LD_Q: begin
        cmd.lat_b = 1'b1;
        state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  `KPI_ASSERT_NEXT(a_load_decode, in_valid && in_ready, state_r == ST_DECODE, "request not decoded")

endmodule

[design/kpi_dp.sv]
// datapath of the keyframe interpolator: stores, scan index, divider, blend
// depends on kpi_pkg, kpi_ram and the macros header
`timescale 1ns / 1ps
`include "keyframe_position_interpolator_macros.svh"

module kpi_dp #(
  parameter int MAX_POINTS = 64,
  parameter int MAX_FRAMES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  kpi_pkg::cmd_t   cmd,
  output kpi_pkg::sts_t   sts,
  input  logic            cfg_we,
  input  logic [10:0]     cfg_wdata,
  input  logic [1:0]      in_kind,
  input  logic [5:0]      in_point,
  input  logic [9:0]      in_frame_index,
  input  logic [19:0]     in_pos_x,
  input  logic [19:0]     in_pos_y,
  input  logic            in_key_flag,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [19:0]     out_x,
  output logic [19:0]     out_y,
  output logic            out_found
);

  import kpi_pkg::*;

  localparam int DEPTH = MAX_POINTS * MAX_FRAMES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  cnt_t            fc_r;
  cnt_t            n_eff;
  logic [AW-1:0]   clr_r;
  kind_t           kind_r;
  logic [5:0]      pt_r;
  cnt_t            f_r;
  coord_t          x_r, y_r;
  logic            key_r;
  logic [AW-1:0]   base_r;
  cnt_t            idx_r, prev_r, next_r;
  logic            has_prev_r, has_next_r;
  logic [NW:0]     rem_r;
  cnt_t            d_r;
  logic [WW-1:0]   w_r;
  logic [3:0]      dcnt_r;
  coord_t          ax_r, ay_r, bx_r, by_r;
  logic signed [37:0] prod_r;
  coord_t          res_x_r, res_y_r;
  logic            res_found_r;
  logic            out_valid_r;
  coord_t          out_x_r, out_y_r;
  logic            out_found_r;

  logic            pt_ok, f_ok;
  cnt_t            rsel_idx;
  logic [AW-1:0]   raddr, waddr;
  logic            pos_we, key_we, cur_we;
  logic [2*CW-1:0] pos_wdata, cur_wdata, pos_rdata, cur_rdata;
  logic            key_wdata, key_rdata;
  logic [PW-1:0]   cur_waddr;
  logic [NW:0]     div_t2;
  logic            div_ge;
  logic signed [CW:0]  diff;
  logic signed [38:0]  rnd;
  coord_t          a_sel;
  coord_t          blend_res;

  assign n_eff = (MAX_FRAMES > 2047 || 32'(fc_r) < MAX_FRAMES) ? fc_r : cnt_t'(MAX_FRAMES);
  assign pt_ok = 32'(pt_r) < MAX_POINTS;
  assign f_ok  = f_r < n_eff;

  always_comb begin
    unique case (cmd.rsel)
      RA_F:    rsel_idx = f_r;
      RA_IDX:  rsel_idx = idx_r;
      RA_PREV: rsel_idx = prev_r;
      RA_NEXT: rsel_idx = next_r;
      default: rsel_idx = f_r;
    endcase
  end

  assign raddr     = base_r + AW'(rsel_idx);
  assign waddr     = cmd.clr ? clr_r : base_r + AW'(f_r);
  assign pos_we    = cmd.clr | (cmd.wr & (kind_r == KIND_WR_POS) & pt_ok & f_ok);
  assign key_we    = cmd.clr | (cmd.wr & (kind_r == KIND_WR_KEY) & pt_ok & f_ok);
  assign cur_we    = (cmd.clr & (32'(clr_r) < MAX_POINTS)) |
                     (cmd.wr & (kind_r == KIND_WR_CUR) & pt_ok);
  assign pos_wdata = cmd.clr ? '0 : {y_r, x_r};
  assign cur_wdata = pos_wdata;
  assign key_wdata = cmd.clr ? 1'b0 : key_r;
  assign cur_waddr = cmd.clr ? PW'(clr_r) : PW'(pt_r);

  kpi_ram #(.W(2*CW), .DEPTH(DEPTH), .AW(AW)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wdata),
    .raddr(raddr), .rdata(pos_rdata)
  );

  kpi_ram #(.W(1), .DEPTH(DEPTH), .AW(AW)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rdata)
  );

  kpi_ram #(.W(2*CW), .DEPTH(MAX_POINTS), .AW(PW)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(PW'(pt_r)), .rdata(cur_rdata)
  );

  // restoring divider step
  assign div_t2 = {rem_r[NW-1:0], 1'b0};
  assign div_ge = div_t2 >= {1'b0, d_r};

  // blend: a + round((b - a) * w / 2^16)
  assign a_sel     = cmd.mul_y ? ax_r : ay_r;
  assign rnd       = (39'(prod_r) + 39'sd32768) >>> WW;
  assign blend_res = a_sel + coord_t'(rnd[CW-1:0]);
  assign diff      = cmd.mul_x ? ($signed({bx_r[CW-1], bx_r}) - $signed({ax_r[CW-1], ax_r}))
                               : ($signed({by_r[CW-1], by_r}) - $signed({ay_r[CW-1], ay_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= cnt_t'(1);
      clr_r       <= '0;
      has_prev_r  <= 1'b0;
      has_next_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fc_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.load) begin
        has_prev_r <= 1'b0;
        has_next_r <= 1'b0;
      end
      if (cmd.set_prev) begin
        has_prev_r <= 1'b1;
      end
      if (cmd.set_next) begin
        has_next_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
      pt_r   <= in_point;
      f_r    <= cnt_t'(in_frame_index);
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      key_r  <= in_key_flag;
      base_r <= AW'(AW'(in_point) * AW'(MAX_FRAMES));
    end
    if (cmd.idx_f_m1) begin
      idx_r <= f_r - cnt_t'(1);
    end else if (cmd.idx_f_p1) begin
      idx_r <= f_r + cnt_t'(1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - cnt_t'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + cnt_t'(1);
    end
    if (cmd.set_prev) begin
      prev_r <= idx_r;
    end
    if (cmd.set_next) begin
      next_r <= idx_r;
    end
    if (cmd.div_init) begin
      rem_r  <= {1'b0, f_r - prev_r};
      d_r    <= next_r - prev_r;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? div_t2 - {1'b0, d_r} : div_t2;
      w_r    <= {w_r[WW-2:0], div_ge};
      dcnt_r <= dcnt_r + 4'd1;
    end
    if (cmd.lat_a) begin
      ax_r <= pos_rdata[CW-1:0];
      ay_r <= pos_rdata[2*CW-1:CW];
    end
    if (cmd.lat_b) begin
      bx_r <= pos_rdata[CW-1:0];
      by_r <= pos_rdata[2*CW-1:CW];
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= diff * $signed({1'b0, w_r});
    end
    if (cmd.mul_y) begin
      res_x_r <= blend_res;
    end
    if (cmd.fin) begin
      res_y_r     <= blend_res;
      res_found_r <= 1'b1;
    end
    if (cmd.res_zero) begin
      res_x_r     <= '0;
      res_y_r     <= '0;
      res_found_r <= 1'b0;
    end
    if (cmd.res_cur) begin
      res_x_r     <= cur_rdata[CW-1:0];
      res_y_r     <= cur_rdata[2*CW-1:CW];
      res_found_r <= 1'b0;
    end
    if (cmd.res_pos) begin
      res_x_r     <= pos_rdata[CW-1:0];
      res_y_r     <= pos_rdata[2*CW-1:CW];
      res_found_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_found_r <= res_found_r;
    end
  end

  always_comb begin
    sts.clr_last  = clr_r == AW'(DEPTH - 1);
    sts.kind      = kind_r;
    sts.pt_ok     = pt_ok;
    sts.f_ok      = f_ok;
    sts.key       = key_rdata;
    sts.f_zero    = f_r == '0;
    sts.idx_zero  = idx_r == '0;
    sts.f1_ge_n   = ({1'b0, f_r} + 12'd1) >= {1'b0, n_eff};
    sts.idx1_ge_n = ({1'b0, idx_r} + 12'd1) >= {1'b0, n_eff};
    sts.has_prev  = has_prev_r;
    sts.has_next  = has_next_r;
    sts.div_last  = dcnt_r == 4'd15;
    sts.out_busy  = out_valid_r & ~out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_found = out_found_r;

  `KPI_ASSERT_RST(a_prev_below, has_prev_r |-> (prev_r < f_r), "previous keyframe not below frame")
  `KPI_ASSERT_RST(a_next_above, has_next_r |-> (next_r > f_r), "next keyframe not above frame")

endmodule
